[rtl/nfba_pkg.sv]
`default_nettype none

package nfba_pkg;

  localparam int unsigned NFBA_MAX_BITS = 1024;

  // map word geometry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFF_W  = 5;

  // fixed field widths
  localparam int unsigned FLD_OPC_W = 2;
  localparam int unsigned FLD_IDX_W = 10;
  localparam int unsigned FLD_CNT_W = 11;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [FLD_OPC_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TEST  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FLD_IDX_W-1:0] result_index;
    logic                 full_res;
    logic                 bit_value;
    logic                 bad_index;
    logic [FLD_CNT_W-1:0] free_left;
  } res_t;

  // bits strictly below off set
  function automatic logic [WORD_W-1:0] mask_below(input logic [OFF_W-1:0] off);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (OFF_W'(i) < off);
    end
    return m;
  endfunction

  // bits strictly above off set
  function automatic logic [WORD_W-1:0] mask_above(input logic [OFF_W-1:0] off);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (OFF_W'(i) > off);
    end
    return m;
  endfunction

  // position of the lowest clear bit
  function automatic logic [OFF_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = OFF_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

[rtl/nfba_map_ram.sv]
`default_nettype none

module nfba_map_ram import nfba_pkg::*; #(
  parameter int unsigned MAX_BITS = NFBA_MAX_BITS,
  localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W,
  localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WORD_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [NUM_WORDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/nfba_ctrl.sv]
`default_nettype none

module nfba_ctrl import nfba_pkg::*; #(
  parameter int unsigned MAX_BITS = NFBA_MAX_BITS,
  localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W,
  localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire opcode_e              in_opcode_i,
  input  wire logic [FLD_IDX_W-1:0] in_index_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [FLD_CNT_W-1:0] cfg_data_i,
  input  wire logic                 res_ready_i,
  output logic                      res_valid_o,
  output res_t                      res_o,
  output logic                      wr_en_o,
  output logic      [ADDR_W-1:0]    wr_addr_o,
  output logic      [WORD_W-1:0]    wr_data_o,
  output logic                      rd_en_o,
  output logic      [ADDR_W-1:0]    rd_addr_o,
  input  wire logic [WORD_W-1:0]    rd_data_i
);

  localparam int unsigned BIT_W  = ADDR_W + OFF_W;
  localparam int unsigned SIZE_W = $clog2(MAX_BITS + 1);

  state_e               state_q, state_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [SIZE_W-1:0]    free_q, free_d;
  logic [BIT_W-1:0]     hint_q, hint_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 first_q, first_d;
  opcode_e              op_q, op_d;
  logic [FLD_IDX_W-1:0] idx_q, idx_d;

  logic [SIZE_W-1:0] cfg_size;
  logic              in_bad;
  logic [BIT_W-1:0]  in_bit;
  logic [BIT_W-1:0]  hint_eff;
  logic [BIT_W-1:0]  last_bit;
  logic [BIT_W-1:0]  idx_bit;
  logic [WORD_W-1:0] bit_mask;
  logic              bit_val;
  logic [WORD_W-1:0] masked;
  logic              found;
  logic [OFF_W-1:0]  pos_off;
  logic [BIT_W-1:0]  pos;
  logic [ADDR_W-1:0] next_addr;
  logic [SIZE_W-1:0] free_n;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (32'(cfg_data_i) > MAX_BITS) begin
      cfg_size = SIZE_W'(MAX_BITS);
    end else begin
      cfg_size = SIZE_W'(cfg_data_i);
    end
    in_bad   = 32'(in_index_i) >= 32'(size_q);
    in_bit   = BIT_W'(in_index_i);
    hint_eff = (32'(hint_q) >= 32'(size_q)) ? '0 : hint_q;
    last_bit = BIT_W'(32'(size_q) - 32'd1);
    idx_bit  = BIT_W'(idx_q);
    bit_mask = WORD_W'(1) << idx_bit[OFF_W-1:0];
    bit_val  = rd_data_i[idx_bit[OFF_W-1:0]];
    // treat bits before the hint (first visit) and past the size as used
    masked   = rd_data_i
             | (first_q ? mask_below(hint_eff[OFF_W-1:0]) : '0)
             | ((addr_q == last_bit[BIT_W-1:OFF_W]) ? mask_above(last_bit[OFF_W-1:0]) : '0);
    found    = (masked != '1);
    pos_off  = first_zero(masked);
    pos      = {addr_q, pos_off};
    next_addr = (addr_q == last_bit[BIT_W-1:OFF_W]) ? '0 : addr_q + ADDR_W'(1);
  end

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    free_d  = free_q;
    hint_d  = hint_q;
    addr_d  = addr_q;
    first_d = first_q;
    op_d    = op_q;
    idx_d   = idx_q;
    free_n  = free_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    wr_en_o     = 1'b0;
    wr_addr_o   = addr_q;
    wr_data_o   = '0;
    rd_en_o     = 1'b0;
    rd_addr_o   = addr_q;

    case (state_q)
      ST_CLEAR: begin
        wr_en_o = 1'b1;
        addr_d  = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(NUM_WORDS - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_opcode_i;
          idx_d = in_index_i;
          if (in_opcode_i == OP_ALLOC) begin
            if (free_q == '0) begin
              state_d = ST_DONE;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = hint_eff[BIT_W-1:OFF_W];
              addr_d    = hint_eff[BIT_W-1:OFF_W];
              first_d   = 1'b1;
              state_d   = ST_SCAN;
            end
          end else if (in_bad) begin
            state_d = ST_DONE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = in_bit[BIT_W-1:OFF_W];
            state_d   = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        wr_addr_o = idx_bit[BIT_W-1:OFF_W];
        wr_data_o = rd_data_i;
        if (op_q == OP_SET && !bit_val) begin
          wr_data_o = rd_data_i | bit_mask;
          wr_en_o   = res_ready_i;
          free_n    = free_q - SIZE_W'(1);
        end else if (op_q == OP_CLEAR && bit_val) begin
          wr_data_o = rd_data_i & ~bit_mask;
          wr_en_o   = res_ready_i;
          free_n    = free_q + SIZE_W'(1);
        end
        res_valid_o        = 1'b1;
        res_o.result_index = idx_q;
        res_o.bit_value    = bit_val;
        res_o.free_left    = FLD_CNT_W'(free_n);
        if (res_ready_i) begin
          free_d  = free_n;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (found) begin
          res_valid_o        = 1'b1;
          res_o.result_index = FLD_IDX_W'(pos);
          res_o.free_left    = FLD_CNT_W'(free_q - SIZE_W'(1));
          wr_data_o          = rd_data_i | (WORD_W'(1) << pos_off);
          if (res_ready_i) begin
            wr_en_o = 1'b1;
            free_d  = free_q - SIZE_W'(1);
            hint_d  = pos;
            state_d = ST_IDLE;
          end
        end else begin
          // advance to the next word, wrapping past the last active one
          rd_en_o   = 1'b1;
          rd_addr_o = next_addr;
          addr_d    = next_addr;
          first_d   = 1'b0;
        end
      end
      ST_DONE: begin
        res_valid_o     = 1'b1;
        res_o.free_left = FLD_CNT_W'(free_q);
        if (op_q == OP_ALLOC) begin
          res_o.full_res = 1'b1;
        end else begin
          res_o.bad_index    = 1'b1;
          res_o.result_index = idx_q;
        end
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        addr_d  = '0;
      end
    endcase

    // a size write restarts the whole map
    if (cfg_valid_i) begin
      size_d  = cfg_size;
      free_d  = cfg_size;
      hint_d  = '0;
      addr_d  = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      size_q  <= SIZE_W'(MAX_BITS);
      free_q  <= SIZE_W'(MAX_BITS);
      hint_q  <= '0;
      addr_q  <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      free_q  <= free_d;
      hint_q  <= hint_d;
      addr_q  <= addr_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    idx_q <= idx_d;
  end

endmodule

`default_nettype wire

[rtl/nfba_out_reg.sv]
`default_nettype none

module nfba_out_reg import nfba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  output logic      res_ready_o,
  input  wire res_t res_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

[rtl/next_fit_bitmap_allocator_top.sv]
// Next-fit bitmap allocator.
// Request stream (s_axis): tuser carries the opcode (allocate, mark used, mark free,
// test), tdata the bit index. Result stream (m_axis): one word per request with the
// allocated or echoed index, the old bit value, the free count after the operation,
// and full/bad-index flags in tuser.
// Config channel (cfg_*): a write of the size register reinitializes the map; the
// size saturates at MAX_BITS. Write it only while no request is outstanding.
// The map lives in a 32-bit-wide single-port-read RAM of ceil(MAX_BITS/32) words.
// After reset and after every size write a clearing pass zeroes one word per cycle
// over all ceil(MAX_BITS/32) words; s_axis_tready stays low meanwhile.
// Mark and test read the map word and present the result from the bit state; a bad
// index or an allocate on a full map goes straight to the result; allocate scans the
// map one RAM word read per cycle, at most ceil(MAX_BITS/32) + 1 words.
// One request is in flight at a time; the next is taken only after the result has
// been handed to the output register.
// A stalled receiver holds the result in the output register; the block finishes
// the next request up to its result and waits there until that register frees up.
`default_nettype none

module next_fit_bitmap_allocator_top import nfba_pkg::*; #(
  parameter int unsigned MAX_BITS = NFBA_MAX_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [9:0] bit_index, [15:10] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  wire logic [FLD_OPC_W-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [9:0] result_index, [10] bit_value, [21:11] free_left, [23:22] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] full_res, [1] bad_index
  output logic      [OUT_TUSER_W-1:0] m_axis_tuser,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [FLD_CNT_W-1:0]   cfg_data_i
);

  localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned PAD_W     = OUT_TDATA_W - FLD_IDX_W - 1 - FLD_CNT_W;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;

  nfba_ctrl #(
    .MAX_BITS(MAX_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_opcode_i(opcode_e'(s_axis_tuser)),
    .in_index_i (s_axis_tdata[FLD_IDX_W-1:0]),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  nfba_map_ram #(
    .MAX_BITS(MAX_BITS)
  ) u_map_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  nfba_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (out_res)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.free_left, out_res.bit_value,
                         out_res.result_index};
  assign m_axis_tuser = {out_res.bad_index, out_res.full_res};

  // a size write starts the clearing pass, which blocks requests
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while busy");

  // a full allocate reports index zero and never a bad index
  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[FLD_IDX_W-1:0] == '0 && !m_axis_tuser[1] && !m_axis_tdata[FLD_IDX_W])
    else $error("full result with stray fields");

  // a bad index never reports a set bit
  a_bad_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tdata[FLD_IDX_W] && !m_axis_tuser[0])
    else $error("bad-index result with stray fields");

endmodule

`default_nettype wire
